### rtl/core/wnm_pkg.sv
// Shared types and constants for the wildcard name matcher.
// Used by wnm_cell, wildcard_name_matcher_unit and the testbench; depends on nothing.
package wnm_pkg;

  localparam int MASK_LEN = 32;

  localparam logic [7:0] CH_ANY  = 8'h3F;  // '?'
  localparam logic [7:0] CH_STAR = 8'h2A;  // '*'

  // Broadcast control from the top level to every cell
  typedef struct packed {
    logic       clr;        // new mask starts: drop stored characters
    logic       wr;         // mask character to store at the first free cell
    logic       name_en;    // name item accepted
    logic       step;       // name item consumes a character
    logic       name_open;  // name already in progress
    logic [7:0] ch;         // character of the item
  } cell_ctl_t;

  // Signals handed from one cell to its right neighbor
  typedef struct packed {
    logic used;   // left cell holds a mask character
    logic lead;   // position reachable from the start through stars only
    logic adv;    // active position advanced into this one on a character
    logic carry;  // star closure rippling forward
  } cell_link_t;

endpackage

### rtl/core/wnm_cell.sv
// One mask position of the matcher chain: stored character, fill flag,
// leading-star flag and NFA active bit. Depends on wnm_pkg.
module wnm_cell import wnm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  cell_ctl_t  ctl,
  input  cell_link_t link_in,
  output cell_link_t link_out,
  output logic       end_hit
);

  logic [7:0] ch_r;
  logic       used_r, used_nxt;
  logic       lead_r, lead_nxt;
  logic       act_r, act_nxt;

  logic used_eff, wr_here;
  logic is_star, ch_hit;
  logic base, nxt, val, is_end;

  assign used_eff = used_r & ~ctl.clr;
  assign wr_here  = ctl.wr & link_in.used & ~used_eff;

  assign is_star = (ch_r == CH_STAR);
  assign ch_hit  = (ch_r == CH_ANY) | (ch_r == ctl.ch);

  // A fresh name starts from the leading-star set, already closed
  assign base = ctl.name_open ? act_r : link_in.lead;
  assign nxt  = (base & used_r & is_star) | link_in.adv | link_in.carry;
  assign val  = ctl.step ? nxt : base;

  assign is_end  = link_in.used & ~used_r;
  assign end_hit = is_end & val;

  assign link_out.used  = used_eff;
  assign link_out.lead  = lead_r;
  assign link_out.adv   = base & used_r & ~is_star & ch_hit;
  assign link_out.carry = nxt & used_r & is_star;

  always_comb begin
    used_nxt = used_r;
    lead_nxt = lead_r;
    act_nxt  = act_r;
    if (ctl.clr) begin
      used_nxt = 1'b0;
      lead_nxt = 1'b0;
    end
    if (wr_here) begin
      used_nxt = 1'b1;
      lead_nxt = link_in.lead & (ctl.ch == CH_STAR);
    end
    if (ctl.name_en) begin
      act_nxt = val;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= 1'b0;
      lead_r <= 1'b0;
      act_r  <= 1'b0;
    end else begin
      used_r <= used_nxt;
      lead_r <= lead_nxt;
      act_r  <= act_nxt;
    end
  end

  // Character payload, no reset
  always_ff @(posedge clk) begin
    if (wr_here) begin
      ch_r <= ctl.ch;
    end
  end

endmodule

### rtl/core/wildcard_name_matcher_unit.sv
// Wildcard name matcher top level: control, cell chain and result register.
// Depends on wnm_pkg and wnm_cell.
//
// Usage: stream a mask (in_cmd 0), one character per item, in_last on the
// final one; in_empty_req 1 on a fresh mask gives an empty mask. Then stream
// a name (in_cmd 1); the item that carries in_last or in_empty_req produces
// one result on out_match / out_status. '?' matches one character, '*' any
// run. Masks longer than MASK_LEN characters report out_status 1, match 0.
// Throughput: one item per cycle, mask and name alike, while in_stall is low.
// Latency: the result is valid in the cycle after its ending item is taken.
// The clock is set by the star-closure chain, which ripples combinationally
// like a carry through all MASK_LEN cells, plus the end-position OR.
// The result sits in an output register; while it is stalled in_stall is
// high and no item is taken. Once it drains, items flow again at once.
// Reset (rst_n low, synchronous) clears mask length, open flags, overflow
// and the position set; the result register comes up empty.
module wildcard_name_matcher_unit import wnm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  input  logic       in_empty_req,
  output logic       out_valid,
  input  logic       out_stall,
  output logic       out_match,
  output logic       out_status
);

  cell_ctl_t  ctl;
  cell_link_t links [MASK_LEN+1];
  logic [MASK_LEN:0]   end_hits;
  logic [MASK_LEN-1:0] used_vec;

  logic acc, ends, hit;
  logic mask_open_r, mask_open_nxt;
  logic name_open_r, name_open_nxt;
  logic ovf_r, ovf_nxt;
  logic act_top_r, act_top_nxt;
  logic top_base, top_nxt, top_val;
  logic out_valid_r, out_valid_nxt;
  logic out_match_r, out_status_r;

  assign in_stall = out_valid_r & out_stall;
  assign acc      = in_valid & ~in_stall;
  assign ends     = in_last | in_empty_req;

  assign ctl.clr       = acc & ~in_cmd & ~mask_open_r;
  assign ctl.wr        = acc & ~in_cmd & ~in_empty_req;
  assign ctl.name_en   = acc & in_cmd;
  assign ctl.step      = ~in_empty_req;
  assign ctl.name_open = name_open_r;
  assign ctl.ch        = in_ch;

  assign links[0] = '{used: 1'b1, lead: 1'b1, adv: 1'b0, carry: 1'b0};

  for (genvar i = 0; i < MASK_LEN; i++) begin : g_cell
    wnm_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .ctl      (ctl),
      .link_in  (links[i]),
      .link_out (links[i+1]),
      .end_hit  (end_hits[i])
    );
    assign used_vec[i] = links[i+1].used;
  end

  // Final position past the last cell: nothing stored here
  assign top_base = name_open_r ? act_top_r : links[MASK_LEN].lead;
  assign top_nxt  = links[MASK_LEN].adv | links[MASK_LEN].carry;
  assign top_val  = ctl.step ? top_nxt : top_base;
  assign end_hits[MASK_LEN] = links[MASK_LEN].used & top_val;

  assign hit = (|end_hits) & ~ovf_r;

  always_comb begin
    mask_open_nxt = mask_open_r;
    name_open_nxt = name_open_r;
    ovf_nxt       = ovf_r;
    act_top_nxt   = act_top_r;
    if (acc && !in_cmd) begin
      name_open_nxt = 1'b0;
      if (!mask_open_r) begin
        ovf_nxt = 1'b0;
      end
      // Chain full: drop the character and flag the mask
      if (!in_empty_req && links[MASK_LEN].used) begin
        ovf_nxt = 1'b1;
      end
      mask_open_nxt = ~ends;
    end else if (acc && in_cmd) begin
      mask_open_nxt = 1'b0;
      name_open_nxt = ~ends;
      act_top_nxt   = top_val;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r & out_stall;
    if (acc && in_cmd && ends) begin
      out_valid_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask_open_r <= 1'b0;
      name_open_r <= 1'b0;
      ovf_r       <= 1'b0;
      act_top_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      mask_open_r <= mask_open_nxt;
      name_open_r <= name_open_nxt;
      ovf_r       <= ovf_nxt;
      act_top_r   <= act_top_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (acc && in_cmd && ends) begin
      out_match_r  <= hit;
      out_status_r <= ovf_r;
    end
  end

  assign out_valid  = out_valid_r;
  assign out_match  = out_match_r;
  assign out_status = out_status_r;

  // Filled cells always form a prefix of the chain
  a_used_prefix: assert property (@(posedge clk) disable iff (!rst_n)
    ((used_vec >> 1) & ~used_vec) == '0)
    else $error("mask cells not filled as a prefix");

  // Overflow only after every cell holds a character; a new mask drops both
  a_ovf_full: assert property (@(posedge clk) disable iff (!rst_n)
    (ovf_r && !ctl.clr) |-> used_vec[MASK_LEN-1])
    else $error("overflow flagged with free cells");

  // A mask and a name are never open together
  a_open_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(mask_open_r && name_open_r))
    else $error("mask and name open at once");

  // Overflowed mask never reports a match
  a_ovf_nomatch: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r) |-> !out_match_r)
    else $error("match reported on overflowed mask");

  // A name item that ends its string yields a result next cycle
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (acc && in_cmd && ends) |=> out_valid_r)
    else $error("ending name item gave no result");

endmodule

### tb/wildcard_match_checker.sv
// Checker for the wildcard name matcher: watches both channels, predicts
// each glob match result and compares it with what the block returns.
// Depends on wnm_pkg for MASK_LEN and the wildcard characters.
`timescale 1ns / 100ps

module wildcard_match_checker import wnm_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  input  logic       in_stall,
  input  logic       in_cmd,
  input  logic [7:0] in_ch,
  input  logic       in_last,
  input  logic       in_empty_req,
  input  logic       out_valid,
  input  logic       out_stall,
  input  logic       out_match,
  input  logic       out_status,
  output int         fail_count,
  output int         outstanding
);

  typedef struct packed {
    logic match;
    logic status;
  } glob_res_t;

  glob_res_t pending_matches[$];

  logic [7:0]      mask_chars [MASK_LEN];
  int unsigned     mask_cnt;
  bit              mask_loading;
  bit              mask_over;
  bit              name_busy;
  bit [MASK_LEN:0] live;

  initial begin
    fail_count  = 0;
    outstanding = 0;
  end

  // Let active star positions skip forward without consuming a character
  function automatic bit [MASK_LEN:0] star_close(bit [MASK_LEN:0] v);
    for (int i = 0; i < mask_cnt; i++) begin
      if (v[i] && mask_chars[i] == CH_STAR) v[i+1] = 1'b1;
    end
    return v;
  endfunction

  always @(posedge clk) begin : monitor
    glob_res_t       got;
    glob_res_t       want;
    bit [MASK_LEN:0] nxt;
    if (!rst_n) begin
      mask_cnt     = 0;
      mask_loading = 1'b0;
      mask_over    = 1'b0;
      name_busy    = 1'b0;
      live         = '0;
      pending_matches.delete();
    end else begin
      // Check the result first: it belongs to an item taken on an earlier edge
      if (out_valid && !out_stall) begin
        got.match  = out_match;
        got.status = out_status;
        if (pending_matches.size() == 0) begin
          $error("result with no item waiting: match %0b status %0b",
                 got.match, got.status);
          fail_count++;
        end else begin
          want = pending_matches.pop_front();
          if (got.match !== want.match) begin
            $error("match: expected %0b, got %0b", want.match, got.match);
            fail_count++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0b, got %0b", want.status, got.status);
            fail_count++;
          end
        end
      end

      if (in_valid && !in_stall) begin
        if (!in_cmd) begin
          // Mask item; the first one after a closed mask starts a new mask
          if (!mask_loading) begin
            mask_cnt     = 0;
            mask_over    = 1'b0;
            mask_loading = 1'b1;
            name_busy    = 1'b0;
          end
          if (!in_empty_req) begin
            if (mask_cnt < MASK_LEN) begin
              mask_chars[mask_cnt] = in_ch;
              mask_cnt++;
            end else begin
              mask_over = 1'b1;
            end
          end
          if (in_last || in_empty_req) mask_loading = 1'b0;
        end else begin
          mask_loading = 1'b0;
          if (!name_busy) begin
            live    = '0;
            live[0] = 1'b1;
            live    = star_close(live);
            name_busy = 1'b1;
          end
          if (!in_empty_req) begin
            nxt = '0;
            for (int i = 0; i < mask_cnt; i++) begin
              if (live[i]) begin
                if (mask_chars[i] == CH_STAR) nxt[i] = 1'b1;
                else if (mask_chars[i] == CH_ANY || mask_chars[i] == in_ch) nxt[i+1] = 1'b1;
              end
            end
            live = star_close(nxt);
          end
          if (in_last || in_empty_req) begin
            name_busy   = 1'b0;
            want.match  = live[mask_cnt] && !mask_over;
            want.status = mask_over;
            pending_matches = {pending_matches, want};
          end
        end
      end
    end
    outstanding = pending_matches.size();
  end

endmodule

### tb/wildcard_name_matcher_unit_tb.sv
// Testbench top for wildcard_name_matcher_unit: clock, reset, mask and name
// stimulus, receiver stalls and the verdict. Depends on wnm_pkg, the block
// and wildcard_match_checker.
`timescale 1ns / 100ps

module wildcard_name_matcher_unit_tb import wnm_pkg::*; ();

  localparam logic CMD_MASK = 1'b0;
  localparam logic CMD_NAME = 1'b1;

  // How a mask or name is closed
  localparam int END_LAST  = 0;
  localparam int END_EMPTY = 1;
  localparam int END_OPEN  = 2;

  localparam int RANDOM_ITEMS = 1100;
  localparam int QUIET_LIMIT  = 5000;
  localparam int HOLD_CYCLES  = 300;
  localparam int IDLE_PCT     = 36;

  typedef logic [7:0] text_t[$];

  logic       clk          = 1'b0;
  logic       rst_n        = 1'b0;
  logic       in_valid     = 1'b0;
  logic       in_cmd       = 1'b0;
  logic [7:0] in_ch        = 8'h00;
  logic       in_last      = 1'b0;
  logic       in_empty_req = 1'b0;
  logic       out_stall    = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic       out_match;
  logic       out_status;

  int fail_count;
  int outstanding;
  int items_sent  = 0;
  int quiet_cycles = 0;
  bit calm        = 1'b0;
  bit hold_go     = 1'b0;

  always #5 clk = ~clk;

  wildcard_name_matcher_unit u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_ch        (in_ch),
    .in_last      (in_last),
    .in_empty_req (in_empty_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_match    (out_match),
    .out_status   (out_status)
  );

  wildcard_match_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_cmd       (in_cmd),
    .in_ch        (in_ch),
    .in_last      (in_last),
    .in_empty_req (in_empty_req),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_match    (out_match),
    .out_status   (out_status),
    .fail_count   (fail_count),
    .outstanding  (outstanding)
  );

  // Watchdog: end the run when no item moves on either channel for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) quiet_cycles <= 0;
      else quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("SCOREBOARD MISMATCH");
        $finish;
      end
    end
  end

  // Receiver: random stalls, one long hold-off on request, none while calm
  initial begin
    forever begin
      @(posedge clk);
      if (hold_go) begin
        hold_go = 1'b0;
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else if (calm) begin
        out_stall <= 1'b0;
      end else begin
        out_stall <= ($urandom_range(0, 99) < IDLE_PCT);
      end
    end
  end

  task automatic send_item(input logic cmd, input logic [7:0] ch, input logic last,
                           input logic empty);
    bit taken;
    while (!calm && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_cmd       <= cmd;
    in_ch        <= ch;
    in_last      <= last;
    in_empty_req <= empty;
    taken = 1'b0;
    // Sample the stall mid-cycle, then step to the edge that takes the item
    while (!taken) begin
      @(negedge clk);
      taken = !in_stall;
      @(posedge clk);
    end
    items_sent++;
  endtask

  task automatic send_text(input logic cmd, input text_t text, input int end_mode);
    int n;
    n = text.size();
    if (n == 0 && end_mode == END_LAST) begin
      send_item(cmd, 8'($urandom), 1'b1, 1'b1);
    end else begin
      for (int i = 0; i < n; i++) begin
        send_item(cmd, text[i], (end_mode == END_LAST && i == n - 1), 1'b0);
      end
      if (end_mode == END_EMPTY) send_item(cmd, 8'($urandom), 1'($urandom_range(0, 1)), 1'b1);
    end
  endtask

  function automatic text_t make_mask();
    text_t m;
    int    len;
    int    r;
    r = $urandom_range(0, 99);
    if (r < 70) len = $urandom_range(0, 6);
    else if (r < 93) len = $urandom_range(7, MASK_LEN);
    else len = $urandom_range(MASK_LEN + 1, MASK_LEN + 8);
    for (int i = 0; i < len; i++) begin
      r = $urandom_range(0, 99);
      if (r < 20) m = {m, CH_STAR};
      else if (r < 35) m = {m, CH_ANY};
      else if (r < 90) m = {m, 8'(8'("a") + 8'($urandom_range(0, 2)))};
      else m = {m, 8'($urandom)};
    end
    return m;
  endfunction

  // Build a name that fits the mask, then break it now and then
  function automatic text_t name_for(input text_t mask);
    text_t nm;
    int    pos;
    foreach (mask[i]) begin
      if (mask[i] == CH_STAR) begin
        repeat ($urandom_range(0, 3)) nm = {nm, 8'(8'("a") + 8'($urandom_range(0, 2)))};
      end else if (mask[i] == CH_ANY) begin
        if ($urandom_range(0, 9) == 0) nm = {nm, 8'($urandom)};
        else nm = {nm, 8'(8'("a") + 8'($urandom_range(0, 2)))};
      end else begin
        nm = {nm, mask[i]};
      end
    end
    if ($urandom_range(0, 99) < 30) begin
      case ($urandom_range(0, 2))
        0: begin
          if (nm.size() > 0) begin
            pos = $urandom_range(0, nm.size() - 1);
            nm[pos] = 8'($urandom);
          end
        end
        1: nm = {nm, 8'(8'("a") + 8'($urandom_range(0, 2)))};
        default: begin
          if (nm.size() > 0) nm.pop_back();
        end
      endcase
    end
    return nm;
  endfunction

  function automatic int pick_end(input int last_pct, input int empty_pct);
    int r;
    r = $urandom_range(0, 99);
    if (r < last_pct) return END_LAST;
    if (r < last_pct + empty_pct) return END_EMPTY;
    return END_OPEN;
  endfunction

  initial begin
    text_t mask;
    text_t nm;
    int    stop_at;
    bit    pressure_done;
    pressure_done = 1'b0;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Name against the empty mask left by reset, then an empty name
    send_item(CMD_NAME, "a", 1'b1, 1'b0);
    send_item(CMD_NAME, 8'h00, 1'b1, 1'b1);
    // Literal and single-character wildcard
    send_text(CMD_MASK, '{"a", CH_ANY, "c"}, END_LAST);
    send_text(CMD_NAME, '{"a", "b", "c"}, END_LAST);
    // Lone star against an empty name
    send_text(CMD_MASK, '{CH_STAR}, END_LAST);
    send_item(CMD_NAME, 8'hFF, 1'b0, 1'b1);
    // Extreme byte values
    send_text(CMD_MASK, '{8'hFF, 8'h00}, END_LAST);
    send_text(CMD_NAME, '{8'hFF, 8'h00}, END_LAST);
    // Name closes an open mask; an empty item ends the name without last
    send_item(CMD_MASK, "a", 1'b0, 1'b0);
    send_item(CMD_NAME, "a", 1'b0, 1'b0);
    send_item(CMD_NAME, 8'hFF, 1'b0, 1'b1);
    // A new mask abandons a name in progress
    send_item(CMD_NAME, "b", 1'b0, 1'b0);
    send_text(CMD_MASK, '{CH_STAR}, END_LAST);
    send_item(CMD_NAME, "q", 1'b1, 1'b0);
    // Empty mask on a fresh mask, then an empty name
    send_item(CMD_MASK, 8'h55, 1'b1, 1'b1);
    send_item(CMD_NAME, 8'hAA, 1'b1, 1'b1);

    stop_at = items_sent + RANDOM_ITEMS;
    while (items_sent < stop_at) begin
      if (!pressure_done && items_sent > 400) begin
        hold_go = 1'b1;
        pressure_done = 1'b1;
      end
      calm = (items_sent >= 650 && items_sent < 850);
      if ($urandom_range(0, 99) < 8) begin
        // Noise: any field combination
        repeat ($urandom_range(1, 4)) begin
          send_item(1'($urandom_range(0, 1)), 8'($urandom), 1'($urandom_range(0, 1)),
                    1'($urandom_range(0, 1)));
        end
      end else begin
        mask = make_mask();
        send_text(CMD_MASK, mask, pick_end(80, 10));
        repeat ($urandom_range(1, 4)) begin
          if ($urandom_range(0, 99) < 15) begin
            nm.delete();
            repeat ($urandom_range(0, 5)) nm = {nm, 8'($urandom)};
          end else begin
            nm = name_for(mask);
          end
          send_text(CMD_NAME, nm, pick_end(70, 20));
        end
      end
    end
    calm = 1'b0;
    in_valid <= 1'b0;

    do @(negedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
